/* hdl/mtsg_pkg.sv */
`default_nettype none

package mtsg_pkg;

    localparam int TIME_W  = 64;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] TICKS_PER_US      = TIME_W'(10);
    localparam logic [TIME_W-1:0] INIT_MARGIN_TICKS = TIME_W'(10000);

    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 64;

    typedef enum logic {
        OP_INIT = 1'b0,
        OP_GET  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_LIMIT        = 2'd0,
        REG_LOCAL_CEILING     = 2'd1,
        REG_MAX_SAME_US_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        op_t               opcode;
        logic [TIME_W-1:0] sys_time_us;
        logic              sys_time_valid;
        logic [TIME_W-1:0] mono_time_us;
        logic              mono_time_valid;
        logic [TIME_W-1:0] max_item_time;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  time_limit;
        logic [TIME_W-1:0]  local_ceiling;
        logic [COUNT_W-1:0] max_same_us_count;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] timestamp;
        logic              status;
    } result_t;

endpackage

`default_nettype wire

/* hdl/mtsg_cfg_regs.sv */
`default_nettype none

module mtsg_cfg_regs
    import mtsg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.time_limit        <= '1;
            cfg_reg.local_ceiling     <= '1;
            cfg_reg.max_same_us_count <= COUNT_W'(9);
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_wr_index))
                REG_TIME_LIMIT:        cfg_reg.time_limit        <= cfg_wr_data;
                REG_LOCAL_CEILING:     cfg_reg.local_ceiling     <= cfg_wr_data;
                REG_MAX_SAME_US_COUNT: cfg_reg.max_same_us_count <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/mtsg_engine.sv */
`default_nettype none

module mtsg_engine
    import mtsg_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  advance,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    logic [TIME_W-1:0]  last_sys_us_reg,     last_sys_us_next;
    logic [COUNT_W-1:0] same_us_count_reg,   same_us_count_next;
    logic [TIME_W-1:0]  last_mono_time_reg,  last_mono_time_next;
    logic               last_mono_valid_reg, last_mono_valid_next;
    logic [TIME_W-1:0]  local_offset_reg,    local_offset_next;
    logic [TIME_W-1:0]  last_local_time_reg, last_local_time_next;

    logic [COUNT_W-1:0] count_upd;
    logic [TIME_W-1:0]  sys_ticks;
    logic [TIME_W-1:0]  local_time;
    logic [TIME_W-1:0]  delta;
    logic               init_fail;
    logic               repair;
    logic               fallback;

    always_comb begin
        // sub-microsecond count for repeated samples, saturating
        if (item.sys_time_us == last_sys_us_reg) begin
            count_upd = (same_us_count_reg < cfg.max_same_us_count)
                      ? same_us_count_reg + COUNT_W'(1) : same_us_count_reg;
        end else begin
            count_upd = '0;
        end

        sys_ticks = item.sys_time_valid
                  ? TIME_W'(item.sys_time_us * TICKS_PER_US) + TIME_W'(count_upd)
                  : '0;
        local_time = sys_ticks + local_offset_reg;

        init_fail = !item.sys_time_valid
                 || (sys_ticks > cfg.time_limit)
                 || (item.max_item_time > cfg.time_limit);
        repair = (local_time <= item.max_item_time)
              || (local_time > cfg.local_ceiling);

        delta = (item.mono_time_valid && last_mono_valid_reg)
              ? item.mono_time_us - last_mono_time_reg : TIME_W'(1);
        fallback = !item.sys_time_valid
                || (local_time <= last_local_time_reg)
                || (local_time > cfg.local_ceiling);

        last_sys_us_next     = last_sys_us_reg;
        same_us_count_next   = same_us_count_reg;
        last_mono_time_next  = last_mono_time_reg;
        last_mono_valid_next = last_mono_valid_reg;
        local_offset_next    = local_offset_reg;
        last_local_time_next = last_local_time_reg;

        if (item.sys_time_valid) begin
            last_sys_us_next   = item.sys_time_us;
            same_us_count_next = count_upd;
        end

        result.timestamp = '0;
        result.status    = 1'b0;

        if (item.opcode == OP_INIT) begin
            result.status = init_fail;
            if (!init_fail) begin
                last_mono_time_next  = item.mono_time_us;
                last_mono_valid_next = item.mono_time_valid;
                if (repair) begin
                    local_offset_next    = item.max_item_time - sys_ticks + INIT_MARGIN_TICKS;
                    last_local_time_next = item.max_item_time + INIT_MARGIN_TICKS;
                end else begin
                    last_local_time_next = local_time;
                end
            end
        end else begin
            last_mono_time_next  = item.mono_time_us;
            last_mono_valid_next = item.mono_time_valid;
            last_local_time_next = fallback ? last_local_time_reg + delta : local_time;
            result.timestamp     = last_local_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sys_us_reg     <= '0;
            same_us_count_reg   <= '0;
            last_mono_time_reg  <= '0;
            last_mono_valid_reg <= 1'b1;
            local_offset_reg    <= '0;
            last_local_time_reg <= '0;
        end else if (advance) begin
            last_sys_us_reg     <= last_sys_us_next;
            same_us_count_reg   <= same_us_count_next;
            last_mono_time_reg  <= last_mono_time_next;
            last_mono_valid_reg <= last_mono_valid_next;
            local_offset_reg    <= local_offset_next;
            last_local_time_reg <= last_local_time_next;
        end
    end

    // a rejected init leaves offset and issued time alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.opcode == OP_INIT && result.status
        |=> $stable(local_offset_reg) && $stable(last_local_time_reg))
        else $error("rejected init changed clock state");

    // an issued time becomes the new floor
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.opcode == OP_GET
        |=> last_local_time_reg == $past(result.timestamp))
        else $error("issued time not recorded");

    // an invalid system sample leaves the sub-count state alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item.sys_time_valid
        |=> $stable(same_us_count_reg) && $stable(last_sys_us_reg))
        else $error("sub-count changed on invalid system sample");

endmodule

`default_nettype wire

/* hdl/monotonic_timestamp_generator_core.sv */
// An accepted beat passes the input register, then the result register, to m_.
// Throughput: one beat per cycle, if m_ does not stall; the issued-time update
//   is one pass of compare and add logic between the input and result registers.
// Reset: aresetn is synchronous, active low; it empties both registers,
//   restores register defaults and clears the clock state.
`default_nettype none

module monotonic_timestamp_generator_core
    import mtsg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [63:0] sys_time_us, [64] sys_time_valid, [128:65] mono_time_us,
    // [129] mono_time_valid, [193:130] max_item_time, [199:194] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  wire logic [0:0]           s_tuser,
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [63:0] timestamp
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [0] status
    output logic [0:0]                m_tuser,
    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_result_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    s_beat;

    mtsg_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Move the held beat to the result register whenever that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    // Input register: capture a beat, hold it while the result side stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_item_reg.opcode          <= op_t'(s_tuser[0]);
            in_item_reg.sys_time_us     <= s_tdata[63:0];
            in_item_reg.sys_time_valid  <= s_tdata[64];
            in_item_reg.mono_time_us    <= s_tdata[128:65];
            in_item_reg.mono_time_valid <= s_tdata[129];
            in_item_reg.max_item_time   <= s_tdata[193:130];
        end
    end

    // Clock state and the per-beat computation; state advances with the beat
    mtsg_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Result register: drop the beat once taken, load the next in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_result_reg.timestamp;
    assign m_tuser[0] = out_result_reg.status;

endmodule

`default_nettype wire

/* test/mtsg_stamp_checker.sv */
`timescale 1ns / 1ps

module mtsg_stamp_checker
    import mtsg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]           s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic [0:0]           m_tuser,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    output int                        fail_count,
    output int                        outstanding,
    output int                        results_seen
);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_TIME = 1'b1;

    // shadow of the clock state and the registers
    logic [TIME_W-1:0]  seen_us;
    logic [COUNT_W-1:0] same_count;
    logic [TIME_W-1:0]  mono_prev;
    logic               mono_prev_ok;
    logic [TIME_W-1:0]  offset;
    logic [TIME_W-1:0]  issued;
    logic [TIME_W-1:0]  valid_limit;
    logic [TIME_W-1:0]  buffer_limit;
    logic [COUNT_W-1:0] same_limit;

    result_t stamps_due[$];
    item_t   req;
    result_t want;

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch: %s", $time, what);
    endtask

    // Work out the stamp and status for one request and advance the shadow state.
    task automatic issue_time(input item_t rq, output result_t res);
        logic [TIME_W-1:0] sys_ticks;
        logic [TIME_W-1:0] virt;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] delta;
        sys_ticks = '0;
        res = '0;
        res.status = STATUS_OK;
        if (rq.sys_time_valid) begin
            if (rq.sys_time_us == seen_us) begin
                if (same_count < same_limit)
                    same_count = same_count + 1'b1;
            end else begin
                seen_us    = rq.sys_time_us;
                same_count = '0;
            end
            sys_ticks = rq.sys_time_us * TICKS_PER_US + TIME_W'(same_count);
        end
        if (rq.opcode == OP_INIT) begin
            if (!rq.sys_time_valid || sys_ticks > valid_limit
                    || rq.max_item_time > valid_limit) begin
                res.status = STATUS_BAD_TIME;
            end else begin
                virt = sys_ticks + offset;
                if (virt <= rq.max_item_time || virt > buffer_limit)
                    offset = rq.max_item_time - sys_ticks + INIT_MARGIN_TICKS;
                mono_prev    = rq.mono_time_us;
                mono_prev_ok = rq.mono_time_valid;
                issued       = sys_ticks + offset;
            end
        end else begin
            stamp = sys_ticks + offset;
            delta = TIME_W'(1);
            if (rq.mono_time_valid && mono_prev_ok)
                delta = rq.mono_time_us - mono_prev;
            mono_prev    = rq.mono_time_us;
            mono_prev_ok = rq.mono_time_valid;
            // take the monotonic step unless the stamp is valid, newer and in range
            if (!rq.sys_time_valid || stamp <= issued || stamp > buffer_limit) begin
                issued = issued + delta;
                stamp  = issued;
            end else begin
                issued = stamp;
            end
            res.timestamp = stamp;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seen_us      = '0;
            same_count   = '0;
            mono_prev    = '0;
            mono_prev_ok = 1'b1;
            offset       = '0;
            issued       = '0;
            valid_limit  = '1;
            buffer_limit = '1;
            same_limit   = COUNT_W'(9);
            stamps_due.delete();
            fail_count   = 0;
            outstanding  = 0;
            results_seen = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_TIME_LIMIT:        valid_limit  = cfg_wr_data;
                    REG_LOCAL_CEILING:     buffer_limit = cfg_wr_data;
                    REG_MAX_SAME_US_COUNT: same_limit   = cfg_wr_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                req.opcode          = op_t'(s_tuser[0]);
                req.sys_time_us     = s_tdata[63:0];
                req.sys_time_valid  = s_tdata[64];
                req.mono_time_us    = s_tdata[128:65];
                req.mono_time_valid = s_tdata[129];
                req.max_item_time   = s_tdata[193:130];
                issue_time(req, want);
                stamps_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (stamps_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat stamp %h status %b",
                                            m_tdata, m_tuser));
                end else begin
                    want = stamps_due.pop_front();
                    if (m_tdata !== want.timestamp || m_tuser[0] !== want.status)
                        note_mismatch($sformatf(
                            "stamp %h status %b, expected stamp %h status %b",
                            m_tdata, m_tuser, want.timestamp, want.status));
                end
            end
            outstanding = stamps_due.size();
        end
    end

endmodule

/* test/tb_monotonic_timestamp_generator_core.sv */
`timescale 1ns / 1ps

module tb_monotonic_timestamp_generator_core;
    import mtsg_pkg::*;

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 206;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;    // extra wait after the last result
    localparam int HOLD_OFF       = 64;   // long receiver stall, in cycles
    localparam logic [TIME_W-1:0] ALL_ONES = '1;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_tvalid     = 1'b0;
    // [63:0] sys_time_us, [64] sys_time_valid, [128:65] mono_time_us,
    // [129] mono_time_valid, [193:130] max_item_time, [199:194] zero
    logic [S_TDATA_W-1:0] s_tdata      = '0;
    // [0] opcode
    logic [0:0]           s_tuser      = '0;
    logic                 m_tready     = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data  = '0;

    wire logic                 s_tready;
    wire logic                 m_tvalid;
    // [63:0] timestamp
    wire logic [M_TDATA_W-1:0] m_tdata;
    // [0] status
    wire logic [0:0]           m_tuser;

    int fail_count;
    int outstanding;
    int results_seen;

    // handshake pressure knobs, percent of cycles
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int holds_asked    = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    // bookkeeping for the closing summary
    int sent       = 0;
    int inits_sent = 0;
    int writes     = 0;

    // running wall and monotonic clocks that shape the well-formed requests
    logic [TIME_W-1:0] wall_us;
    logic [TIME_W-1:0] mono_us;
    int                same_run;

    monotonic_timestamp_generator_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    mtsg_stamp_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .results_seen(results_seen)
    );

    always #6 aclk = ~aclk;

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks
    // for one. The hold-off is counted here so the sender keeps pushing meanwhile.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_OFF;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: abort when neither channel moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved in %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, outstanding);
            $display("FAIL monotonic_timestamp_generator_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t make_req(input op_t op, input logic [TIME_W-1:0] sys,
                                       input logic sys_ok, input logic [TIME_W-1:0] mono,
                                       input logic mono_ok,
                                       input logic [TIME_W-1:0] max_item);
        item_t r;
        r.opcode          = op;
        r.sys_time_us     = sys;
        r.sys_time_valid  = sys_ok;
        r.mono_time_us    = mono;
        r.mono_time_valid = mono_ok;
        r.max_item_time   = max_item;
        return r;
    endfunction

    // Offer one request beat, with random idle cycles ahead of it; return once
    // it is taken. Valid stays high so back-to-back beats need no extra step.
    task automatic send_request(input item_t req);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.opcode;
        s_tdata  <= {6'b0, req.max_item_time, req.mono_time_valid, req.mono_time_us,
                     req.sys_time_valid, req.sys_time_us};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
        if (req.opcode == OP_INIT)
            inits_sent++;
    endtask

    // Drop valid, wait for every result, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        writes++;
    endtask

    // Reprogram all three registers with the block idle.
    task automatic configure(input logic [TIME_W-1:0] limit, input logic [TIME_W-1:0] buffer,
                             input logic [COUNT_W-1:0] same);
        drain();
        write_reg(REG_TIME_LIMIT, limit);
        write_reg(REG_LOCAL_CEILING, buffer);
        write_reg(REG_MAX_SAME_US_COUNT, CFG_W'(same));
    endtask

    // Mostly well-formed traffic on the running clocks, plus backward steps,
    // repeated microseconds, invalid samples, resyncs and full-range noise.
    function automatic item_t next_req();
        int pick;
        logic [TIME_W-1:0] max_item;
        pick = $urandom_range(0, 99);
        mono_us = mono_us + TIME_W'($urandom_range(0, 20));
        if (same_run > 0) begin
            same_run--;
            return make_req(OP_GET, wall_us, 1'b1, mono_us, 1'b1, rand64());
        end
        if (pick < 55) begin
            wall_us = wall_us + TIME_W'($urandom_range(0, 4));
            return make_req(OP_GET, wall_us, $urandom_range(0, 19) != 0, mono_us,
                            $urandom_range(0, 19) != 0, rand64());
        end else if (pick < 62) begin
            // burst of identical microsecond samples to push the sub-count
            same_run = $urandom_range(2, 20);
            return make_req(OP_GET, wall_us, 1'b1, mono_us, 1'b1, rand64());
        end else if (pick < 70) begin
            wall_us = wall_us - TIME_W'($urandom_range(1, 50));
            return make_req(OP_GET, wall_us, 1'b1, mono_us, $urandom_range(0, 4) != 0,
                            rand64());
        end else if (pick < 78) begin
            max_item = wall_us * TICKS_PER_US + TIME_W'($urandom_range(0, 10000))
                       - TIME_W'(5000);
            return make_req(OP_INIT, wall_us, 1'b1, mono_us, $urandom_range(0, 9) != 0,
                            max_item);
        end else if (pick < 83) begin
            return make_req($urandom_range(0, 1) ? OP_GET : OP_INIT, rand64(), 1'b0,
                            rand64(), 1'($urandom_range(0, 1)), rand64());
        end else if (pick < 88) begin
            return make_req(OP_GET, rand64(), 1'($urandom_range(0, 1)), rand64(),
                            1'($urandom_range(0, 1)), rand64());
        end else if (pick < 92) begin
            return make_req(OP_INIT, rand64(), 1'($urandom_range(0, 1)), rand64(),
                            1'($urandom_range(0, 1)), rand64());
        end else if (pick < 96) begin
            // jump the monotonic clock anywhere
            mono_us = rand64();
            wall_us = wall_us + 1;
            return make_req(OP_GET, wall_us, 1'b1, mono_us, 1'b1, rand64());
        end else begin
            // new epoch: move the wall clock and resync with an init
            wall_us = $urandom_range(0, 1) ? rand64() : TIME_W'($urandom);
            mono_us = rand64();
            return make_req(OP_INIT, wall_us, 1'b1, mono_us, 1'b1,
                            wall_us * TICKS_PER_US - TIME_W'($urandom_range(0, 3000)));
        end
    endfunction

    initial begin
        logic [TIME_W-1:0] now_ticks;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, register defaults, no idling ----
        // plain issue, then the same microsecond again to build the sub-count
        send_request(make_req(OP_GET, 100, 1'b1, 1000, 1'b1, 0));
        repeat (3) send_request(make_req(OP_GET, 100, 1'b1, 1001, 1'b1, 0));
        // backward wall sample: advance by the monotonic delta
        send_request(make_req(OP_GET, 99, 1'b1, 1010, 1'b1, 0));
        // invalid wall sample forces the fallback
        send_request(make_req(OP_GET, 101, 1'b0, 1011, 1'b1, 0));
        // invalid monotonic sample, then a fallback that must step by one
        send_request(make_req(OP_GET, 102, 1'b1, 1012, 1'b0, 0));
        send_request(make_req(OP_GET, 50, 1'b1, 1020, 1'b1, 0));
        // init with an invalid wall sample reports bad time
        send_request(make_req(OP_INIT, 200, 1'b0, 0, 1'b1, 0));
        // item time at the top of the range: offset repair wraps
        send_request(make_req(OP_INIT, 200, 1'b1, 5, 1'b1, ALL_ONES));
        send_request(make_req(OP_GET, 201, 1'b1, 9, 1'b1, 0));
        // tick multiply wraps; monotonic extremes
        send_request(make_req(OP_GET, ALL_ONES, 1'b1, ALL_ONES, 1'b1, ALL_ONES));
        send_request(make_req(OP_GET, 0, 1'b1, 0, 1'b1, 0));
        send_request(make_req(OP_INIT, 300, 1'b1, 20, 1'b1, 0));
        send_request(make_req(OP_INIT, ALL_ONES, 1'b1, 0, 1'b0, 0));
        // tight time limit: one init passes, one fails on wall ticks, one on item time
        configure(TIME_W'(5000), ALL_ONES, 9);
        send_request(make_req(OP_INIT, 400, 1'b1, 0, 1'b1, 0));
        send_request(make_req(OP_INIT, 600, 1'b1, 0, 1'b1, 0));
        send_request(make_req(OP_INIT, 400, 1'b1, 0, 1'b1, TIME_W'(5001)));
        // buffer limit below the issued time: repair at init, fallback at get
        configure(ALL_ONES, TIME_W'(4500), 0);
        send_request(make_req(OP_INIT, 500, 1'b1, 30, 1'b1, TIME_W'(100)));
        send_request(make_req(OP_GET, 501, 1'b1, 40, 1'b1, 0));
        send_request(make_req(OP_GET, 501, 1'b1, 47, 1'b1, 0));
        send_request(make_req(OP_GET, 502, 1'b0, 50, 1'b0, 0));

        // ---- random part: one register setting and one handshake mode per phase ----
        wall_us  = TIME_W'(1000000);
        mono_us  = TIME_W'(5000000);
        same_run = 0;
        for (int p = 0; p < PHASES; p++) begin
            now_ticks = wall_us * TICKS_PER_US;
            case (p)
                0: configure(ALL_ONES, ALL_ONES, 9);
                1: configure(ALL_ONES, ALL_ONES, 0);
                2: configure('0, '0, 255);
                3: configure(now_ticks + TIME_W'($urandom_range(0, 100000)),
                             now_ticks + TIME_W'($urandom_range(0, 5000)), 3);
                4: configure(ALL_ONES, now_ticks + TIME_W'($urandom_range(0, 20000)), 1);
                5: configure(ALL_ONES, ALL_ONES, COUNT_W'($urandom_range(0, 255)));
                6: configure(rand64(), rand64(), 9);
                default: configure(ALL_ONES, ALL_ONES, 9);
            endcase
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            // resync the offset to the running wall clock
            send_request(make_req(OP_INIT, wall_us, 1'b1, mono_us, 1'b1,
                                  now_ticks - TIME_W'(1000)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the result side off while requests keep coming
                if (n == 40 && p % 4 < 2)
                    holds_asked++;
                send_request(next_req());
            end
        end

        // ---- wind down ----
        drain();
        $display("Covered %0d requests (%0d init) over %0d register writes,",
                 sent, inits_sent, writes);
        $display("four handshake modes and long result hold-offs; %0d results compared.",
                 results_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS monotonic_timestamp_generator_core");
        end else begin
            $display("FAIL monotonic_timestamp_generator_core");
        end
        $finish;
    end

endmodule
